### design/assert_macros.svh
// Assertion macros shared by the occupancy grid RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define POG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define POG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pog_pkg.sv
// Types, constants and coefficient tables for the occupancy grid unit.
`timescale 1ns / 1ps

package pog_pkg;

    // Grid size defaults
    localparam int GRID_ROWS_DEF = 256;
    localparam int GRID_COLS_DEF = 256;
    localparam int IDX_W         = 12;   // any row or column below the largest grid side

    // Field and port widths
    localparam int CMD_W      = 2;
    localparam int PT_W       = 32;
    localparam int RC_W       = 8;
    localparam int VAL_W      = 7;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QUAT_W     = 16;
    localparam int OFF_W      = 31;
    localparam int INV_W      = 25;

    // Datapath widths
    localparam int ENT_W   = 18;   // rotation entry, Q3.14
    localparam int QPROD_W = 32;   // quaternion product, Q3.28
    localparam int QSUM_W  = 36;   // entry before rounding, Q28
    localparam int MA_W    = 33;   // multiplier operand a
    localparam int MB_W    = 26;   // multiplier operand b
    localparam int MP_W    = 59;   // multiplier product
    localparam int ACC_W   = 52;   // sum of three rotation products
    localparam int RND_W   = 38;   // rotated coordinate, Q16.16
    localparam int SHF_W   = 40;   // coordinate after offset
    localparam int BIN_W   = 25;   // bin index from the reciprocal multiply
    localparam int STEP_W  = 5;
    localparam int MAT_N   = 9;
    localparam int MAT_IDX_W = 4;

    // Fixed point constants
    localparam int FRAC_SH = 14;
    localparam logic [VAL_W-1:0] OCC_VALUE = 7'd100;
    localparam logic signed [QSUM_W-1:0] Q_RND        = 36'sd8192;
    localparam logic signed [QSUM_W-1:0] Q28_ONE_RND  = 36'sd268443648;
    localparam logic signed [QSUM_W-1:0] ENT_MAX_Q    = 36'sd131071;
    localparam logic signed [QSUM_W-1:0] ENT_MIN_Q    = -36'sd131072;
    localparam logic signed [ENT_W-1:0]  ENT_MAX      = 18'sd131071;
    localparam logic signed [ENT_W-1:0]  ENT_MIN      = -18'sd131072;
    localparam logic signed [ACC_W-1:0]  ROT_RND      = 52'sd8192;

    // Sequencer step counts
    localparam logic [STEP_W-1:0] QENT_LAST = 5'd18;   // 18 products plus drain
    localparam logic [STEP_W-1:0] ROT_LAST  = 5'd6;    // 6 products plus drain
    localparam logic [STEP_W-1:0] BIN_LAST  = 5'd2;    // 2 products plus drain

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME = 2'd0,
        CMD_POINT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W  = 3'd0,
        REG_QUAT_X  = 3'd1,
        REG_QUAT_Y  = 3'd2,
        REG_QUAT_Z  = 3'd3,
        REG_OFF_X   = 3'd4,
        REG_OFF_Y   = 3'd5,
        REG_INV_RES = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        QC_W = 2'd0,
        QC_X = 2'd1,
        QC_Y = 2'd2,
        QC_Z = 2'd3
    } quat_comp_t;

    typedef enum logic [1:0] {
        GOP_NONE  = 2'd0,
        GOP_CLEAR = 2'd1,
        GOP_READ  = 2'd2,
        GOP_MARK  = 2'd3
    } grid_op_t;

    typedef struct packed {
        grid_op_t         op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } grid_req_t;

    typedef struct packed {
        quat_comp_t ca;
        quat_comp_t cb;
        logic       neg;
    } mat_term_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_QENT,
        ST_ROT,
        ST_ROUND,
        ST_SHIFT,
        ST_BIN,
        ST_HIT,
        ST_MARK,
        ST_READ,
        ST_READ_WAIT,
        ST_OUT
    } pog_state_t;

    // Two product terms per rotation entry, entry = t / 2, each scaled by two
    function automatic mat_term_t mat_term(input logic [STEP_W-1:0] t);
        mat_term_t r;
        case (t)
            5'd0:    r = '{ca: QC_Y, cb: QC_Y, neg: 1'b1};
            5'd1:    r = '{ca: QC_Z, cb: QC_Z, neg: 1'b1};
            5'd2:    r = '{ca: QC_X, cb: QC_Y, neg: 1'b0};
            5'd3:    r = '{ca: QC_Z, cb: QC_W, neg: 1'b1};
            5'd4:    r = '{ca: QC_X, cb: QC_Z, neg: 1'b0};
            5'd5:    r = '{ca: QC_Y, cb: QC_W, neg: 1'b0};
            5'd6:    r = '{ca: QC_X, cb: QC_Y, neg: 1'b0};
            5'd7:    r = '{ca: QC_Z, cb: QC_W, neg: 1'b0};
            5'd8:    r = '{ca: QC_X, cb: QC_X, neg: 1'b1};
            5'd9:    r = '{ca: QC_Z, cb: QC_Z, neg: 1'b1};
            5'd10:   r = '{ca: QC_Y, cb: QC_Z, neg: 1'b0};
            5'd11:   r = '{ca: QC_X, cb: QC_W, neg: 1'b1};
            5'd12:   r = '{ca: QC_X, cb: QC_Z, neg: 1'b0};
            5'd13:   r = '{ca: QC_Y, cb: QC_W, neg: 1'b1};
            5'd14:   r = '{ca: QC_Y, cb: QC_Z, neg: 1'b0};
            5'd15:   r = '{ca: QC_X, cb: QC_W, neg: 1'b0};
            5'd16:   r = '{ca: QC_X, cb: QC_X, neg: 1'b1};
            5'd17:   r = '{ca: QC_Y, cb: QC_Y, neg: 1'b1};
            default: r = '{ca: QC_W, cb: QC_W, neg: 1'b0};
        endcase
        return r;
    endfunction

    // Diagonal entries start from one
    function automatic logic is_diag(input logic [MAT_IDX_W-1:0] e);
        return (e == 4'd0) || (e == 4'd4) || (e == 4'd8);
    endfunction

endpackage

### design/pog_grid.sv
// Row-organized occupancy memory with clear, read and read-modify-write mark.
`timescale 1ns / 1ps

module pog_grid #(
    parameter int GRID_ROWS = pog_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = pog_pkg::GRID_COLS_DEF
) (
    input  logic                aclk,
    input  pog_pkg::grid_req_t  grid_req,
    output logic                occ_bit
);

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int COL_W = $clog2(GRID_COLS);

    logic [GRID_COLS-1:0] mem [GRID_ROWS];
    logic [GRID_COLS-1:0] rdata_reg;
    logic [GRID_COLS-1:0] mark_row;
    logic [ROW_W-1:0]     row_a;
    logic [COL_W-1:0]     col_a;

    assign row_a = grid_req.row[ROW_W-1:0];
    assign col_a = grid_req.col[COL_W-1:0];

    // Set the chosen bit in the row last fetched into rdata_reg
    assign mark_row = rdata_reg | (GRID_COLS'(1) << col_a);

    // Single port: clear a row, fetch a row, or write back a marked row
    always_ff @(posedge aclk) begin
        case (grid_req.op)
            pog_pkg::GOP_CLEAR: mem[row_a] <= '0;
            pog_pkg::GOP_MARK:  mem[row_a] <= mark_row;
            pog_pkg::GOP_READ:  rdata_reg  <= mem[row_a];
            default: ;
        endcase
    end

    // Pick one cell from the fetched row
    assign occ_bit = rdata_reg[col_a];

endmodule

### design/point_rotate_occupancy_grid_unit.sv
// Top level of the point rotation and occupancy grid unit.
// Commands arrive one at a time on the s_ stream (cmd in s_tuser) and each gives exactly
// one result on the m_ stream. A frame start clears the grid, one row per cycle, then forms
// the rotation matrix from the quaternion registers with the shared multiplier, two products
// per entry. A point goes through six rotation products, round, offset, two binning
// products and, on a hit, a read-modify-write of one grid row. All products go through
// one registered 33 x 26 multiplier, which sets the point latency; the grid is one row
// per memory word, which sets the clear time. After reset the block runs the same clear
// pass before it takes a command; configuration writes are taken at any time but are
// meant only while the block is idle. A finished result sits in the output register,
// so the next command is taken while it waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module point_rotate_occupancy_grid_unit #(
    parameter int GRID_ROWS = pog_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = pog_pkg::GRID_COLS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_x, point_y, point_z, read_row, read_col
    input  logic [pog_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd
    input  logic [pog_pkg::CMD_W-1:0]        s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cell_row, cell_col, cell_value, one pad bit
    output logic [pog_pkg::M_TDATA_W-1:0]    m_tdata,
    // hit
    output logic [0:0]                       m_tuser,
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pog_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pog_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int LIM_W = pog_pkg::IDX_W + 1;
    localparam logic [LIM_W-1:0] ROWS_LIM = LIM_W'(GRID_ROWS);
    localparam logic [LIM_W-1:0] COLS_LIM = LIM_W'(GRID_COLS);
    localparam logic [pog_pkg::BIN_W-1:0] ROWS_BIN = pog_pkg::BIN_W'(GRID_ROWS);
    localparam logic [pog_pkg::BIN_W-1:0] COLS_BIN = pog_pkg::BIN_W'(GRID_COLS);
    localparam logic [ROW_W-1:0] CLR_LAST = ROW_W'(GRID_ROWS - 1);

    // sequencer
    pog_pkg::pog_state_t                 state_reg, state_next;
    logic [pog_pkg::STEP_W-1:0]          step_reg, step_next;
    logic [pog_pkg::STEP_W-1:0]          recv_k;
    logic [ROW_W-1:0]                    clr_row_reg, clr_row_next;
    logic                                frame_reg, frame_next;
    logic                                in_xfer;

    // command payload
    logic signed [pog_pkg::PT_W-1:0]     px_reg, py_reg, pz_reg;
    logic [pog_pkg::RC_W-1:0]            rrow_reg, rcol_reg;

    // configuration
    logic signed [pog_pkg::QUAT_W-1:0]   qw_reg, qx_reg, qy_reg, qz_reg;
    logic [pog_pkg::OFF_W-1:0]           offx_reg, offy_reg;
    logic [pog_pkg::INV_W-1:0]           inv_reg;

    // rotation matrix
    logic signed [pog_pkg::ENT_W-1:0]    mat_reg [pog_pkg::MAT_N];
    logic                                mat_we;
    logic [pog_pkg::MAT_IDX_W-1:0]       mat_widx;
    logic signed [pog_pkg::ENT_W-1:0]    mat_wdata;

    // shared multiplier
    logic signed [pog_pkg::MA_W-1:0]     mul_a;
    logic signed [pog_pkg::MB_W-1:0]     mul_b;
    logic signed [pog_pkg::MP_W-1:0]     prod_full, prod_reg;

    // matrix forming
    pog_pkg::mat_term_t                  iss_term, rcv_term;
    logic signed [pog_pkg::QUAT_W-1:0]   q_a, q_b;
    logic signed [pog_pkg::QSUM_W-1:0]   qacc_reg, qacc_next;
    logic signed [pog_pkg::QSUM_W-1:0]   qterm2, qterm_s, qsum, qrnd;
    logic signed [pog_pkg::ENT_W-1:0]    ent_sat;

    // point path
    logic signed [pog_pkg::PT_W-1:0]     coord;
    logic signed [pog_pkg::ENT_W-1:0]    ent_rd;
    logic signed [pog_pkg::ACC_W-1:0]    acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic signed [pog_pkg::ACC_W-1:0]    rot_base, rot_sum;
    logic signed [pog_pkg::RND_W-1:0]    rnd_x_reg, rnd_x_next, rnd_y_reg, rnd_y_next;
    logic signed [pog_pkg::SHF_W-1:0]    sx_x_reg, sx_x_next, sx_y_reg, sx_y_next;
    logic [pog_pkg::BIN_W-1:0]           col_bin_reg, col_bin_next, row_bin_reg, row_bin_next;
    logic                                in_x, in_y, hit_now, rd_in_grid;

    // result
    logic                                res_hit_reg, res_hit_next;
    logic [pog_pkg::RC_W-1:0]            res_row_reg, res_row_next, res_col_reg, res_col_next;
    logic [pog_pkg::VAL_W-1:0]           res_val_reg, res_val_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [pog_pkg::M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                                m_tuser_reg, m_tuser_next;

    // grid
    pog_pkg::grid_req_t                  grid_req;
    logic                                occ_bit;

    pog_grid #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_grid (
        .aclk     (aclk),
        .grid_req (grid_req),
        .occ_bit  (occ_bit)
    );

    assign s_tready  = (state_reg == pog_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Take register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qw_reg   <= 16'sd16384;
            qx_reg   <= '0;
            qy_reg   <= '0;
            qz_reg   <= '0;
            offx_reg <= 31'd1638400;
            offy_reg <= 31'd1638400;
            inv_reg  <= 25'd655360;
        end else if (cfg_valid) begin
            case (pog_pkg::cfg_reg_t'(cfg_index))
                pog_pkg::REG_QUAT_W:  qw_reg   <= $signed(cfg_data[pog_pkg::QUAT_W-1:0]);
                pog_pkg::REG_QUAT_X:  qx_reg   <= $signed(cfg_data[pog_pkg::QUAT_W-1:0]);
                pog_pkg::REG_QUAT_Y:  qy_reg   <= $signed(cfg_data[pog_pkg::QUAT_W-1:0]);
                pog_pkg::REG_QUAT_Z:  qz_reg   <= $signed(cfg_data[pog_pkg::QUAT_W-1:0]);
                pog_pkg::REG_OFF_X:   offx_reg <= cfg_data[pog_pkg::OFF_W-1:0];
                pog_pkg::REG_OFF_Y:   offy_reg <= cfg_data[pog_pkg::OFF_W-1:0];
                pog_pkg::REG_INV_RES: inv_reg  <= cfg_data[pog_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the command payload on transfer
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            px_reg   <= $signed(s_tdata[31:0]);
            py_reg   <= $signed(s_tdata[63:32]);
            pz_reg   <= $signed(s_tdata[95:64]);
            rrow_reg <= s_tdata[103:96];
            rcol_reg <= s_tdata[111:104];
        end
    end

    // Rotation matrix, zero until the first frame start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pog_pkg::MAT_N; i++) begin
                mat_reg[i] <= '0;
            end
        end else if (mat_we) begin
            mat_reg[mat_widx] <= mat_wdata;
        end
    end

    // Shared multiplier, registered
    assign prod_full = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full;
    end

    // Step whose product is in prod_reg
    assign recv_k   = step_reg - 5'd1;
    assign iss_term = pog_pkg::mat_term(step_reg);
    assign rcv_term = pog_pkg::mat_term(recv_k);

    // Quaternion component select for the two multiplier inputs
    always_comb begin
        case (iss_term.ca)
            pog_pkg::QC_W: q_a = qw_reg;
            pog_pkg::QC_X: q_a = qx_reg;
            pog_pkg::QC_Y: q_a = qy_reg;
            default:       q_a = qz_reg;
        endcase
        case (iss_term.cb)
            pog_pkg::QC_W: q_b = qw_reg;
            pog_pkg::QC_X: q_b = qx_reg;
            pog_pkg::QC_Y: q_b = qy_reg;
            default:       q_b = qz_reg;
        endcase
    end

    // Entry arithmetic: twice the product, signed, rounded to Q14, saturated
    assign qterm2 = $signed({{(pog_pkg::QSUM_W - pog_pkg::QPROD_W - 1)
                              {prod_reg[pog_pkg::QPROD_W-1]}},
                             prod_reg[pog_pkg::QPROD_W-1:0], 1'b0});
    assign qterm_s = rcv_term.neg ? -qterm2 : qterm2;
    assign qsum    = qacc_reg + qterm_s;
    assign qrnd    = qsum >>> pog_pkg::FRAC_SH;

    always_comb begin
        if (qrnd > pog_pkg::ENT_MAX_Q) begin
            ent_sat = pog_pkg::ENT_MAX;
        end else if (qrnd < pog_pkg::ENT_MIN_Q) begin
            ent_sat = pog_pkg::ENT_MIN;
        end else begin
            ent_sat = $signed(qrnd[pog_pkg::ENT_W-1:0]);
        end
    end

    // Rotation operands: x row uses entries 0..2, y row 3..5
    assign ent_rd = mat_reg[step_reg[pog_pkg::MAT_IDX_W-1:0]];

    always_comb begin
        if (step_reg == 5'd0 || step_reg == 5'd3) begin
            coord = px_reg;
        end else if (step_reg == 5'd1 || step_reg == 5'd4) begin
            coord = py_reg;
        end else begin
            coord = pz_reg;
        end
    end

    assign rot_base = (recv_k == 5'd0 || recv_k == 5'd3) ? '0 :
                      (recv_k < 5'd3) ? acc_x_reg : acc_y_reg;
    assign rot_sum  = rot_base + $signed(prod_reg[pog_pkg::ACC_W-1:0]);

    // Extent checks: 0 <= shifted < 2 * offset
    assign in_x = !sx_x_reg[pog_pkg::SHF_W-1] &&
                  (sx_x_reg[pog_pkg::SHF_W-2:0] <
                   {{(pog_pkg::SHF_W - 2 - pog_pkg::OFF_W){1'b0}}, offx_reg, 1'b0});
    assign in_y = !sx_y_reg[pog_pkg::SHF_W-1] &&
                  (sx_y_reg[pog_pkg::SHF_W-2:0] <
                   {{(pog_pkg::SHF_W - 2 - pog_pkg::OFF_W){1'b0}}, offy_reg, 1'b0});
    assign hit_now = in_x && in_y && (col_bin_reg < COLS_BIN) && (row_bin_reg < ROWS_BIN);

    assign rd_in_grid = (LIM_W'(rrow_reg) < ROWS_LIM) && (LIM_W'(rcol_reg) < COLS_LIM);

    // State and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pog_pkg::ST_CLEAR;
            step_reg     <= '0;
            clr_row_reg  <= '0;
            frame_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            clr_row_reg  <= clr_row_next;
            frame_reg    <= frame_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        qacc_reg    <= qacc_next;
        acc_x_reg   <= acc_x_next;
        acc_y_reg   <= acc_y_next;
        rnd_x_reg   <= rnd_x_next;
        rnd_y_reg   <= rnd_y_next;
        sx_x_reg    <= sx_x_next;
        sx_y_reg    <= sx_y_next;
        col_bin_reg <= col_bin_next;
        row_bin_reg <= row_bin_next;
        res_hit_reg <= res_hit_next;
        res_row_reg <= res_row_next;
        res_col_reg <= res_col_next;
        res_val_reg <= res_val_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Sequencer: next state, multiplier operands, grid requests
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        clr_row_next  = clr_row_reg;
        frame_next    = frame_reg;
        qacc_next     = qacc_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        rnd_x_next    = rnd_x_reg;
        rnd_y_next    = rnd_y_reg;
        sx_x_next     = sx_x_reg;
        sx_y_next     = sx_y_reg;
        col_bin_next  = col_bin_reg;
        row_bin_next  = row_bin_reg;
        res_hit_next  = res_hit_reg;
        res_row_next  = res_row_reg;
        res_col_next  = res_col_reg;
        res_val_next  = res_val_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mat_we        = 1'b0;
        mat_widx      = recv_k[pog_pkg::MAT_IDX_W:1];
        mat_wdata     = ent_sat;
        mul_a         = '0;
        mul_b         = '0;
        grid_req      = '{op: pog_pkg::GOP_NONE, row: '0, col: '0};

        case (state_reg)
            pog_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    res_hit_next = 1'b0;
                    res_row_next = '0;
                    res_col_next = '0;
                    res_val_next = '0;
                    step_next    = '0;
                    case (pog_pkg::cmd_t'(s_tuser))
                        pog_pkg::CMD_FRAME: begin
                            frame_next   = 1'b1;
                            clr_row_next = '0;
                            state_next   = pog_pkg::ST_CLEAR;
                        end
                        pog_pkg::CMD_POINT: state_next = pog_pkg::ST_ROT;
                        pog_pkg::CMD_READ:  state_next = pog_pkg::ST_READ;
                        default:            state_next = pog_pkg::ST_OUT;
                    endcase
                end
            end

            // Sweep the grid one row per cycle
            pog_pkg::ST_CLEAR: begin
                grid_req = '{op: pog_pkg::GOP_CLEAR,
                             row: pog_pkg::IDX_W'(clr_row_reg), col: '0};
                if (clr_row_reg == CLR_LAST) begin
                    clr_row_next = '0;
                    frame_next   = 1'b0;
                    step_next    = '0;
                    state_next   = frame_reg ? pog_pkg::ST_QENT : pog_pkg::ST_IDLE;
                end else begin
                    clr_row_next = clr_row_reg + 1'b1;
                end
            end

            // Issue one quaternion product per step, fold two into each entry
            pog_pkg::ST_QENT: begin
                if (step_reg < pog_pkg::QENT_LAST) begin
                    mul_a = $signed({{(pog_pkg::MA_W - pog_pkg::QUAT_W){q_a[pog_pkg::QUAT_W-1]}},
                                     q_a});
                    mul_b = $signed({{(pog_pkg::MB_W - pog_pkg::QUAT_W){q_b[pog_pkg::QUAT_W-1]}},
                                     q_b});
                end
                if (step_reg != '0) begin
                    if (!recv_k[0]) begin
                        qacc_next = (pog_pkg::is_diag(recv_k[pog_pkg::MAT_IDX_W:1]) ?
                                     pog_pkg::Q28_ONE_RND : pog_pkg::Q_RND) + qterm_s;
                    end else begin
                        mat_we = 1'b1;
                    end
                end
                if (step_reg == pog_pkg::QENT_LAST) begin
                    state_next = pog_pkg::ST_OUT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            // Six matrix-by-coordinate products into the x and y sums
            pog_pkg::ST_ROT: begin
                if (step_reg < pog_pkg::ROT_LAST) begin
                    mul_a = $signed({coord[pog_pkg::PT_W-1], coord});
                    mul_b = $signed({{(pog_pkg::MB_W - pog_pkg::ENT_W){ent_rd[pog_pkg::ENT_W-1]}},
                                     ent_rd});
                end
                if (step_reg != '0) begin
                    if (recv_k < 5'd3) begin
                        acc_x_next = rot_sum;
                    end else begin
                        acc_y_next = rot_sum;
                    end
                end
                if (step_reg == pog_pkg::ROT_LAST) begin
                    state_next = pog_pkg::ST_ROUND;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            // Round both sums to Q16.16
            pog_pkg::ST_ROUND: begin
                rnd_x_next = pog_pkg::RND_W'((acc_x_reg + pog_pkg::ROT_RND) >>> pog_pkg::FRAC_SH);
                rnd_y_next = pog_pkg::RND_W'((acc_y_reg + pog_pkg::ROT_RND) >>> pog_pkg::FRAC_SH);
                state_next = pog_pkg::ST_SHIFT;
            end

            // Add the offsets
            pog_pkg::ST_SHIFT: begin
                sx_x_next = $signed({{(pog_pkg::SHF_W - pog_pkg::RND_W){rnd_x_reg[pog_pkg::RND_W-1]}},
                                     rnd_x_reg}) +
                            $signed({{(pog_pkg::SHF_W - pog_pkg::OFF_W){1'b0}}, offx_reg});
                sx_y_next = $signed({{(pog_pkg::SHF_W - pog_pkg::RND_W){rnd_y_reg[pog_pkg::RND_W-1]}},
                                     rnd_y_reg}) +
                            $signed({{(pog_pkg::SHF_W - pog_pkg::OFF_W){1'b0}}, offy_reg});
                step_next  = '0;
                state_next = pog_pkg::ST_BIN;
            end

            // Bin by multiplying with cells per meter, keep the integer part
            pog_pkg::ST_BIN: begin
                if (step_reg < pog_pkg::BIN_LAST) begin
                    mul_a = $signed({1'b0, (step_reg == 5'd0) ? sx_x_reg[pog_pkg::PT_W-1:0] :
                                                              sx_y_reg[pog_pkg::PT_W-1:0]});
                    mul_b = $signed({1'b0, inv_reg});
                end
                if (step_reg == 5'd1) begin
                    col_bin_next = prod_reg[pog_pkg::PT_W+pog_pkg::BIN_W-1:pog_pkg::PT_W];
                end
                if (step_reg == pog_pkg::BIN_LAST) begin
                    row_bin_next = prod_reg[pog_pkg::PT_W+pog_pkg::BIN_W-1:pog_pkg::PT_W];
                    state_next   = pog_pkg::ST_HIT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            // Fetch the row to mark, or drop a miss
            pog_pkg::ST_HIT: begin
                if (hit_now) begin
                    res_hit_next = 1'b1;
                    res_row_next = row_bin_reg[pog_pkg::RC_W-1:0];
                    res_col_next = col_bin_reg[pog_pkg::RC_W-1:0];
                    grid_req     = '{op: pog_pkg::GOP_READ,
                                     row: row_bin_reg[pog_pkg::IDX_W-1:0], col: '0};
                    state_next   = pog_pkg::ST_MARK;
                end else begin
                    state_next = pog_pkg::ST_OUT;
                end
            end

            pog_pkg::ST_MARK: begin
                grid_req   = '{op: pog_pkg::GOP_MARK,
                               row: row_bin_reg[pog_pkg::IDX_W-1:0],
                               col: col_bin_reg[pog_pkg::IDX_W-1:0]};
                state_next = pog_pkg::ST_OUT;
            end

            // Cell read: echo the address, fetch the row when it lies in the grid
            pog_pkg::ST_READ: begin
                res_row_next = rrow_reg;
                res_col_next = rcol_reg;
                if (rd_in_grid) begin
                    grid_req   = '{op: pog_pkg::GOP_READ,
                                   row: pog_pkg::IDX_W'(rrow_reg), col: '0};
                    state_next = pog_pkg::ST_READ_WAIT;
                end else begin
                    state_next = pog_pkg::ST_OUT;
                end
            end

            pog_pkg::ST_READ_WAIT: begin
                grid_req     = '{op: pog_pkg::GOP_NONE,
                                 row: '0, col: pog_pkg::IDX_W'(rcol_reg)};
                res_val_next = occ_bit ? pog_pkg::OCC_VALUE : '0;
                state_next   = pog_pkg::ST_OUT;
            end

            // Hand the result to the output register once it is free
            pog_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_val_reg, res_col_reg, res_row_reg};
                    m_tuser_next  = res_hit_reg;
                    state_next    = pog_pkg::ST_IDLE;
                end
            end

            default: state_next = pog_pkg::ST_IDLE;
        endcase
    end

    // Checks
    `POG_ASSERT_NEXT(a_one_cmd_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready,
                     "command taken while the previous one is still in progress")
    `POG_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, state_reg == pog_pkg::ST_CLEAR,
                    !s_tready, "command taken during the grid clear pass")
    `POG_ASSERT_NOW(a_mark_in_grid, aclk, aresetn, grid_req.op == pog_pkg::GOP_MARK,
                    (LIM_W'(grid_req.row) < ROWS_LIM) && (LIM_W'(grid_req.col) < COLS_LIM),
                    "grid mark outside the grid")
    `POG_ASSERT_NOW(a_hit_has_no_value, aclk, aresetn, m_tvalid && m_tuser[0],
                    m_tdata[22:16] == '0, "point hit carries a cell value")

endmodule
